// ----- rtl/sawbc_pkg.sv -----
package sawbc_pkg;

    // Default geometry
    localparam int DEF_CACHE_BYTES  = 1024;
    localparam int DEF_WAYS         = 2;
    localparam int DEF_BLOCK_BYTES  = 16;
    localparam int DEF_ADDRESS_BITS = 32;

    // Fixed field widths
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;

    // Access kind carried on the input tuser bit
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Counter slots
    localparam int CNT_READ       = 0;
    localparam int CNT_READ_MISS  = 1;
    localparam int CNT_WRITE      = 2;
    localparam int CNT_WRITE_MISS = 3;
    localparam int CNT_WB         = 4;
    localparam int CNT_NUM        = 5;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    // Controller -> datapath
    typedef struct packed {
        logic clear;   // clear one set's state row
        logic load;    // capture item, read set
        logic commit;  // update set, counters, result
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic clear_last;
    } t_dp_sts;

endpackage

// ----- rtl/sawbc_ctrl.sv -----
module sawbc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    input  sawbc_pkg::t_dp_sts i_sts,
    output sawbc_pkg::t_dp_cmd o_cmd
);
    import sawbc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                // finish only once the result slot is free or draining
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;

endmodule

// ----- rtl/sawbc_dp.sv -----
module sawbc_dp #(
    parameter int CACHE_BYTES  = sawbc_pkg::DEF_CACHE_BYTES,
    parameter int WAYS         = sawbc_pkg::DEF_WAYS,
    parameter int BLOCK_BYTES  = sawbc_pkg::DEF_BLOCK_BYTES,
    parameter int ADDRESS_BITS = sawbc_pkg::DEF_ADDRESS_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  sawbc_pkg::t_dp_cmd           i_cmd,
    output sawbc_pkg::t_dp_sts           o_sts,
    input  logic                         i_write,
    input  logic [sawbc_pkg::ADDR_W-1:0] i_addr,
    output logic                         o_hit,
    output logic                         o_fetch,
    output logic                         o_wb,
    output logic [sawbc_pkg::ADDR_W-1:0] o_wb_addr,
    output logic [sawbc_pkg::CNT_W-1:0]  o_read_total,
    output logic [sawbc_pkg::CNT_W-1:0]  o_read_miss_total,
    output logic [sawbc_pkg::CNT_W-1:0]  o_write_total,
    output logic [sawbc_pkg::CNT_W-1:0]  o_write_miss_total,
    output logic [sawbc_pkg::CNT_W-1:0]  o_writeback_total
);
    import sawbc_pkg::*;

    localparam int AW        = ADDRESS_BITS;
    localparam int OFF       = $clog2(BLOCK_BYTES);
    localparam int SETS_RAW  = CACHE_BYTES / (WAYS * BLOCK_BYTES);
    localparam int SET_COUNT = (SETS_RAW > 0) ? SETS_RAW : 1;
    localparam int SB        = $clog2(SET_COUNT);
    localparam int SIW       = (SB > 0) ? SB : 1;
    localparam int TW_RAW    = AW - OFF - SB;
    localparam int TW        = (TW_RAW > 0) ? TW_RAW : 1;
    localparam int AGW       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam logic [AGW-1:0] AGE_OLD = AGW'(WAYS - 1);

    // Set memories: state row is cleared after reset, tag/fill rows are not
    logic [WAYS-1:0]          mem_valid [SET_COUNT];
    logic [WAYS-1:0]          mem_dirty [SET_COUNT];
    logic [WAYS-1:0][AGW-1:0] mem_age   [SET_COUNT];
    logic [WAYS-1:0][TW-1:0]  mem_tag   [SET_COUNT];
    logic [WAYS-1:0][AW-1:0]  mem_fill  [SET_COUNT];

    logic [SIW-1:0]           r_clr_idx;
    logic [SIW-1:0]           r_set;
    logic                     r_write;
    logic [AW-1:0]            r_addr;
    logic [WAYS-1:0]          r_rd_valid;
    logic [WAYS-1:0]          r_rd_dirty;
    logic [WAYS-1:0][AGW-1:0] r_rd_age;
    logic [WAYS-1:0][TW-1:0]  r_rd_tag;
    logic [WAYS-1:0][AW-1:0]  r_rd_fill;

    logic [CNT_W-1:0]         r_cnt [CNT_NUM];
    logic [AW-1:0]            r_victim;
    logic                     r_hit;
    logic                     r_wb;

    logic [SIW-1:0]           n_set;
    logic [TW-1:0]            cur_tag;
    logic [WAYS-1:0]          hit_vec, free_vec, old_vec;
    logic [WAYS-1:0]          hit_sel, free_sel, old_sel, way_sel;
    logic                     any_hit, any_free, victim_dirty;
    logic [AGW-1:0]           prior_age;
    logic [AW-1:0]            victim_fill;
    logic [WAYS-1:0]          n_valid, n_dirty;
    logic [WAYS-1:0][AGW-1:0] n_age;
    logic [WAYS-1:0][TW-1:0]  n_tag;
    logic [WAYS-1:0][AW-1:0]  n_fill;
    logic                     n_wb;
    logic [CNT_NUM-1:0]       cnt_inc;

    assign n_set   = SIW'(i_addr[AW-1:0] >> OFF) & SIW'(SET_COUNT - 1);
    assign cur_tag = TW'(r_addr >> (OFF + SB));

    // clearing pass index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + SIW'(1);
        end
    end
    assign o_sts.clear_last = (r_clr_idx == SIW'(SET_COUNT - 1));

    // item capture and registered set read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_write    <= i_write;
            r_addr     <= i_addr[AW-1:0];
            r_set      <= n_set;
            r_rd_valid <= mem_valid[n_set];
            r_rd_dirty <= mem_dirty[n_set];
            r_rd_age   <= mem_age[n_set];
            r_rd_tag   <= mem_tag[n_set];
            r_rd_fill  <= mem_fill[n_set];
        end
    end

    // way selection: hit, else lowest free way, else oldest way (way 0 fallback)
    always_comb begin
        for (int k = 0; k < WAYS; k++) begin
            hit_vec[k]  = r_rd_valid[k] && (r_rd_tag[k] == cur_tag);
            free_vec[k] = !r_rd_valid[k];
            old_vec[k]  = (r_rd_age[k] == AGE_OLD);
        end
        hit_sel  = hit_vec & (~hit_vec + WAYS'(1));
        free_sel = free_vec & (~free_vec + WAYS'(1));
        old_sel  = (|old_vec) ? (old_vec & (~old_vec + WAYS'(1))) : WAYS'(1);
        any_hit  = |hit_vec;
        any_free = |free_vec;
        if (any_hit) begin
            way_sel = hit_sel;
        end else if (any_free) begin
            way_sel = free_sel;
        end else begin
            way_sel = old_sel;
        end

        prior_age   = '0;
        victim_fill = '0;
        for (int k = 0; k < WAYS; k++) begin
            if (way_sel[k]) begin
                prior_age = prior_age | r_rd_age[k];
            end
            if (old_sel[k]) begin
                victim_fill = victim_fill | r_rd_fill[k];
            end
        end
        victim_dirty = |(old_sel & r_rd_dirty);
        n_wb         = !any_hit && !any_free && victim_dirty;

        n_valid = r_rd_valid;
        n_dirty = r_rd_dirty;
        n_tag   = r_rd_tag;
        n_fill  = r_rd_fill;
        n_age   = r_rd_age;
        for (int k = 0; k < WAYS; k++) begin
            if (r_rd_age[k] < prior_age) begin
                n_age[k] = r_rd_age[k] + AGW'(1);
            end
            if (way_sel[k]) begin
                n_age[k]   = '0;
                n_valid[k] = 1'b1;
                if (any_hit) begin
                    n_dirty[k] = r_rd_dirty[k] | (r_write == CMD_WRITE);
                end else begin
                    n_dirty[k] = (r_write == CMD_WRITE);
                    n_tag[k]   = cur_tag;
                    n_fill[k]  = r_addr;
                end
            end
        end
    end

    // set memory writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            mem_valid[r_clr_idx] <= '0;
            mem_dirty[r_clr_idx] <= '0;
            mem_age[r_clr_idx]   <= {WAYS{AGE_OLD}};
        end else if (i_cmd.commit) begin
            mem_valid[r_set] <= n_valid;
            mem_dirty[r_set] <= n_dirty;
            mem_age[r_set]   <= n_age;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            mem_tag[r_set]  <= n_tag;
            mem_fill[r_set] <= n_fill;
        end
    end

    // saturating counters
    always_comb begin
        cnt_inc                 = '0;
        cnt_inc[CNT_READ]       = (r_write == CMD_READ);
        cnt_inc[CNT_READ_MISS]  = (r_write == CMD_READ) && !any_hit;
        cnt_inc[CNT_WRITE]      = (r_write == CMD_WRITE);
        cnt_inc[CNT_WRITE_MISS] = (r_write == CMD_WRITE) && !any_hit;
        cnt_inc[CNT_WB]         = n_wb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CNT_NUM; i++) begin
                r_cnt[i] <= '0;
            end
            r_victim <= '0;
        end else if (i_cmd.commit) begin
            for (int i = 0; i < CNT_NUM; i++) begin
                if (cnt_inc[i] && (r_cnt[i] != '1)) begin
                    r_cnt[i] <= r_cnt[i] + CNT_W'(1);
                end
            end
            if (n_wb) begin
                r_victim <= victim_fill;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_hit <= any_hit;
            r_wb  <= n_wb;
        end
    end

    assign o_hit              = r_hit;
    assign o_fetch            = !r_hit;
    assign o_wb               = r_wb;
    assign o_wb_addr          = ADDR_W'(r_victim);
    assign o_read_total       = r_cnt[CNT_READ];
    assign o_read_miss_total  = r_cnt[CNT_READ_MISS];
    assign o_write_total      = r_cnt[CNT_WRITE];
    assign o_write_miss_total = r_cnt[CNT_WRITE_MISS];
    assign o_writeback_total  = r_cnt[CNT_WB];

endmodule

// ----- rtl/set_assoc_lru_writeback_cache_core.sv -----
// An accepted item's set row is read into registers; the item is then updated and its result registered on commit.
// The core takes no new item until it has committed the last, owing to the read-modify-write of one set row.
// A result waiting on the output does not block the next item's set read.
// Reset (i_rst_n low, synchronous): counters and last victim address clear, then a
// clearing pass of one set per cycle (32 sets by default) with s_axis_tready low.
module set_assoc_lru_writeback_cache_core #(
    parameter int CACHE_BYTES  = sawbc_pkg::DEF_CACHE_BYTES,
    parameter int WAYS         = sawbc_pkg::DEF_WAYS,
    parameter int BLOCK_BYTES  = sawbc_pkg::DEF_BLOCK_BYTES,
    parameter int ADDRESS_BITS = sawbc_pkg::DEF_ADDRESS_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] address
    input  logic         s_axis_tuser,   // [0] command (0 read, 1 write)
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [0] hit, [1] fetch_next_level, [2] writeback_needed, [34:3] victim_address,
    // [66:35] read_total, [98:67] read_miss_total, [130:99] write_total,
    // [162:131] write_miss_total, [194:163] writeback_total, [199:195] zero
    output logic [199:0] m_axis_tdata
);
    import sawbc_pkg::*;

    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;
    logic             hit, fetch, wb;
    logic [ADDR_W-1:0] wb_addr;
    logic [CNT_W-1:0] read_total, read_miss_total, write_total;
    logic [CNT_W-1:0] write_miss_total, writeback_total;

    // Sequencer: clearing pass, accept, lookup/update
    sawbc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_sts         (dp_sts),
        .o_cmd         (dp_cmd)
    );

    // Set memories, way selection, LRU ages, counters and result registers
    sawbc_dp #(
        .CACHE_BYTES  (CACHE_BYTES),
        .WAYS         (WAYS),
        .BLOCK_BYTES  (BLOCK_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (dp_cmd),
        .o_sts              (dp_sts),
        .i_write            (s_axis_tuser),
        .i_addr             (s_axis_tdata),
        .o_hit              (hit),
        .o_fetch            (fetch),
        .o_wb               (wb),
        .o_wb_addr          (wb_addr),
        .o_read_total       (read_total),
        .o_read_miss_total  (read_miss_total),
        .o_write_total      (write_total),
        .o_write_miss_total (write_miss_total),
        .o_writeback_total  (writeback_total)
    );

    // Result payload holds steady: counters and victim address only move on commit,
    // and commit waits until the previous item has been taken.
    assign m_axis_tdata = {5'b0, writeback_total, write_miss_total, write_total,
                           read_miss_total, read_total, wb_addr, wb, fetch, hit};

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

// Stream-level bench for the set-associative write-back cache core.
// A cycle-free predictor mirrors the tag, valid, dirty, age and fill-address
// state. Every accepted access pushes one predicted result, and a monitor
// compares each output item against the oldest prediction, field by field.
module tb_top;

    import sawbc_pkg::*;

    // Geometry of the instance (package defaults)
    localparam int WAYS      = DEF_WAYS;
    localparam int SETS      = DEF_CACHE_BYTES / (DEF_WAYS * DEF_BLOCK_BYTES);
    localparam int OFF_BITS  = $clog2(DEF_BLOCK_BYTES);
    localparam int SET_BITS  = $clog2(SETS);
    localparam int TAG_W     = ADDR_W - OFF_BITS - SET_BITS;
    localparam logic [ADDR_W-1:0] ADDR_MASK = (DEF_ADDRESS_BITS >= ADDR_W) ? '1 :
                                   ((ADDR_W'(1) << DEF_ADDRESS_BITS) - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Cycles without any item moving before the run is declared hung.
    // The longest legal quiet stretches are the forced output stall and
    // the clearing pass after reset.
    localparam int QUIET_LIMIT   = 3000;
    localparam int RANDOM_ITEMS  = 1300;
    localparam int STEADY_ITEMS  = 300;
    localparam int MAX_REPORTS   = 40;

    // One predicted output item
    typedef struct packed {
        logic              hit;
        logic              fetch;
        logic              wb_needed;
        logic [ADDR_W-1:0] wb_addr;
        logic [CNT_W-1:0]  rd_total;
        logic [CNT_W-1:0]  rd_miss_total;
        logic [CNT_W-1:0]  wr_total;
        logic [CNT_W-1:0]  wr_miss_total;
        logic [CNT_W-1:0]  wb_total;
    } t_access_result;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata  = '0;   // [31:0] address
    logic         s_axis_tuser  = 1'b0; // [0] command (0 read, 1 write)
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // [0] hit, [1] fetch_next_level, [2] writeback_needed, [34:3] victim_address,
    // [66:35] read_total, [98:67] read_miss_total, [130:99] write_total,
    // [162:131] write_miss_total, [194:163] writeback_total, [199:195] zero
    logic [199:0] m_axis_tdata;

    set_assoc_lru_writeback_cache_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: a private copy of the cache directory
    // ---------------------------------------------------------------
    logic [TAG_W-1:0]  dir_tag   [SETS][WAYS];
    bit                dir_valid [SETS][WAYS];
    bit                dir_dirty [SETS][WAYS];
    int                dir_age   [SETS][WAYS];   // 0 = youngest
    logic [ADDR_W-1:0] dir_fill  [SETS][WAYS];   // address that filled the way
    logic [ADDR_W-1:0] last_wb_addr;
    logic [CNT_W-1:0]  access_count [CNT_NUM];

    t_access_result predicted_results [$];

    // Bench bookkeeping
    int  error_count    = 0;
    int  accesses_sent  = 0;
    int  results_seen   = 0;
    int  hits_seen      = 0;
    int  writebacks_seen = 0;
    bit  steady_mode    = 1'b0;  // no idling on either side while set
    int  stall_request  = 0;     // test asks the receiver for a long hold-off
    int  stall_left     = 0;
    int  quiet_cycles   = 0;

    function automatic void count_up(int slot);
        if (access_count[slot] != CNT_MAX)
            access_count[slot] = access_count[slot] + 1;
    endfunction

    // Work out the output item for one access and update the directory.
    function automatic t_access_result predict_access(logic cmd, logic [ADDR_W-1:0] addr);
        t_access_result   res;
        logic [ADDR_W-1:0] a;
        logic [TAG_W-1:0] tag;
        int set_idx;
        int way;
        int prior;
        bit is_hit;
        bit found;
        bit wb;

        a       = addr & ADDR_MASK;          // bits above the address width are dropped
        set_idx = int'((a >> OFF_BITS) % SETS);
        tag     = TAG_W'(a >> (OFF_BITS + SET_BITS));
        is_hit  = 1'b0;
        found   = 1'b0;
        wb      = 1'b0;
        way     = 0;

        count_up(cmd == CMD_WRITE ? CNT_WRITE : CNT_READ);

        for (int w = 0; w < WAYS; w++) begin
            if (!is_hit && dir_valid[set_idx][w] && dir_tag[set_idx][w] == tag) begin
                is_hit = 1'b1;
                way    = w;
            end
        end

        if (is_hit) begin
            if (cmd == CMD_WRITE)
                dir_dirty[set_idx][way] = 1'b1;
        end else begin
            count_up(cmd == CMD_WRITE ? CNT_WRITE_MISS : CNT_READ_MISS);
            // lowest invalid way first
            for (int w = 0; w < WAYS; w++) begin
                if (!found && !dir_valid[set_idx][w]) begin
                    way   = w;
                    found = 1'b1;
                end
            end
            if (!found) begin
                // full set: oldest way, way 0 if ages were ever inconsistent
                way = 0;
                for (int w = WAYS - 1; w >= 0; w--)
                    if (dir_age[set_idx][w] == WAYS - 1)
                        way = w;
                if (dir_dirty[set_idx][way]) begin
                    wb = 1'b1;
                    count_up(CNT_WB);
                    last_wb_addr = dir_fill[set_idx][way];
                end
            end
            dir_tag[set_idx][way]   = tag;
            dir_fill[set_idx][way]  = a;
            dir_valid[set_idx][way] = 1'b1;
            dir_dirty[set_idx][way] = (cmd == CMD_WRITE);
        end

        // touched way becomes youngest, younger ones age by one
        prior = dir_age[set_idx][way];
        for (int w = 0; w < WAYS; w++)
            if (dir_age[set_idx][w] < prior)
                dir_age[set_idx][w] = dir_age[set_idx][w] + 1;
        dir_age[set_idx][way] = 0;

        res.hit           = is_hit;
        res.fetch         = !is_hit;
        res.wb_needed     = wb;
        res.wb_addr       = last_wb_addr;
        res.rd_total      = access_count[CNT_READ];
        res.rd_miss_total = access_count[CNT_READ_MISS];
        res.wr_total      = access_count[CNT_WRITE];
        res.wr_miss_total = access_count[CNT_WRITE_MISS];
        res.wb_total      = access_count[CNT_WB];
        return res;
    endfunction

    function automatic logic [ADDR_W-1:0] make_addr(logic [TAG_W-1:0] tag, int set_idx,
                                                    int offset);
        return {tag, SET_BITS'(set_idx), OFF_BITS'(offset)};
    endfunction

    // ---------------------------------------------------------------
    // Sender: offer one access, wait for the handshake, predict on accept
    // ---------------------------------------------------------------
    task automatic send_access(logic cmd, logic [ADDR_W-1:0] addr);
        // random idle cycles before the item (skipped in steady mode)
        while (!steady_mode && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        s_axis_tuser  <= cmd;
        do
            @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready));
        predicted_results.push_back(predict_access(cmd, addr));
        accesses_sent++;
    endtask

    // ---------------------------------------------------------------
    // Receiver: random back-pressure, or a long forced hold-off on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left     = stall_left - 1;
        end else if (steady_mode) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 21);
        end
    end

    // ---------------------------------------------------------------
    // Result monitor
    // ---------------------------------------------------------------
    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            if (error_count < MAX_REPORTS)
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (m_axis_tdata[0] === 1'b1)
                hits_seen++;
            if (m_axis_tdata[2] === 1'b1)
                writebacks_seen++;
            if (predicted_results.size() == 0) begin
                if (error_count < MAX_REPORTS)
                    $error("result item with no access outstanding");
                error_count++;
            end else begin
                want = predicted_results.pop_front();
                check_field("hit",               32'(want.hit),       32'(m_axis_tdata[0]));
                check_field("fetch_next_level",  32'(want.fetch),     32'(m_axis_tdata[1]));
                check_field("writeback_needed",  32'(want.wb_needed), 32'(m_axis_tdata[2]));
                check_field("victim_address",    want.wb_addr,        m_axis_tdata[34:3]);
                check_field("read_total",        want.rd_total,       m_axis_tdata[66:35]);
                check_field("read_miss_total",   want.rd_miss_total,  m_axis_tdata[98:67]);
                check_field("write_total",       want.wr_total,       m_axis_tdata[130:99]);
                check_field("write_miss_total",  want.wr_miss_total,  m_axis_tdata[162:131]);
                check_field("writeback_total",   want.wb_total,       m_axis_tdata[194:163]);
                check_field("pad",               32'd0,               32'(m_axis_tdata[199:195]));
            end
        end
    end

    // Watchdog: any item moving on either side counts as progress
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
            $display("tb_top: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Fill, hit, write hit marks dirty, second way, then LRU eviction of a
    // dirty way (writeback of its fill address) and of a clean way.
    task automatic test_fill_hit_evict();
        logic [ADDR_W-1:0] a1, a2, a3;
        a1 = make_addr(23'h000001, 3, 4);
        a2 = make_addr(23'h000002, 3, 8);
        a3 = make_addr(23'h07ABCD, 3, 15);
        send_access(CMD_READ,  a1);          // miss, way 0, clean
        send_access(CMD_READ,  a1 ^ 32'h3);  // hit, other offset
        send_access(CMD_WRITE, a1);          // write hit, dirty
        send_access(CMD_READ,  a2);          // miss, way 1
        send_access(CMD_READ,  a3);          // evicts way 0 (dirty) -> writeback a1
        send_access(CMD_READ,  a1);          // evicts way 1 (clean a2)
        send_access(CMD_READ,  a3);          // hit
    endtask

    // Write miss allocates a dirty line; evicting it writes back its fill address.
    task automatic test_write_allocate();
        logic [ADDR_W-1:0] b1, b2, b3;
        b1 = make_addr(23'h155555, 17, 0);
        b2 = make_addr(23'h2AAAAA, 17, 9);
        b3 = make_addr(23'h000777, 17, 2);
        send_access(CMD_WRITE, b1);          // write miss, dirty fill
        send_access(CMD_WRITE, b2);          // write miss, second way dirty
        send_access(CMD_READ,  b3);          // evicts b1 -> writeback
        send_access(CMD_WRITE, b1);          // evicts b2 -> writeback
        send_access(CMD_WRITE, b1);          // write hit on dirty line
    endtask

    // Address extremes: all zeros, all ones, top bit alone, highest set and offset.
    task automatic test_address_extremes();
        send_access(CMD_READ,  32'h0000_0000);
        send_access(CMD_WRITE, 32'hFFFF_FFFF);
        send_access(CMD_READ,  32'h8000_0000);
        send_access(CMD_WRITE, 32'h7FFF_FFFF);
        send_access(CMD_READ,  32'hFFFF_FFF0);   // same line as all ones: hit
        send_access(CMD_WRITE, 32'h0000_000F);   // same line as zero: hit
        send_access(CMD_READ,  32'h0000_01F0);   // tag 0, last set
        send_access(CMD_READ,  32'hFFFF_FE00);   // all-ones tag, set 0
        send_access(CMD_READ,  32'h8000_0001);   // top-bit line, evicted just before: miss
    endtask

    // Output held off for a long stretch while accesses keep coming, so the
    // core fills up and drops s_axis_tready.
    task automatic test_output_backpressure();
        steady_mode   = 1'b1;
        stall_request = 300;
        for (int i = 0; i < 24; i++)
            send_access(CMD_WRITE, make_addr(TAG_W'($urandom), 9 + (i % 3), i % 16));
        steady_mode = 1'b0;
    endtask

    // Random accesses, mostly focused on a few hot sets and tags so that
    // hits, dirty evictions and LRU updates are frequent; the rest is noise.
    task automatic test_random_traffic();
        logic [TAG_W-1:0] tag_pool [8];
        int               hot_sets [4];
        logic [ADDR_W-1:0] addr;
        logic             cmd;
        int               set_idx;
        int               pick;

        tag_pool[0] = '0;
        tag_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            tag_pool[i] = TAG_W'($urandom);
        for (int i = 0; i < 4; i++)
            hot_sets[i] = $urandom_range(SETS - 1);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady_mode = (n < STEADY_ITEMS);   // first stretch runs back to back
            cmd  = logic'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 12) begin
                addr = $urandom;                // noise
            end else begin
                set_idx = (pick < 80) ? hot_sets[$urandom_range(3)] : $urandom_range(SETS - 1);
                // three tags per hot set keep a 2-way set churning
                addr = make_addr(tag_pool[(set_idx + $urandom_range(2)) % 8], set_idx,
                                 $urandom_range(15));
            end
            send_access(cmd, addr);
        end
        steady_mode = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        for (int s = 0; s < SETS; s++)
            for (int w = 0; w < WAYS; w++) begin
                dir_tag[s][w]   = '0;
                dir_valid[s][w] = 1'b0;
                dir_dirty[s][w] = 1'b0;
                dir_age[s][w]   = WAYS - 1;
                dir_fill[s][w]  = '0;
            end
        last_wb_addr = '0;
        for (int c = 0; c < CNT_NUM; c++)
            access_count[c] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // core runs its clearing pass with s_axis_tready low; the sender waits
        test_fill_hit_evict();
        test_write_allocate();
        test_address_extremes();
        test_output_backpressure();
        test_random_traffic();

        @(posedge i_clk);
        s_axis_tvalid <= 1'b0;

        while (predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d accesses, %0d results: %0d hits, %0d dirty evictions",
                 accesses_sent, results_seen, hits_seen, writebacks_seen);
        $display("directed fill/evict, write-allocate, address extremes, long output stall");
        if (error_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
